### rtl/two_register_memory_machine_exec_core_macros.svh
// Assertion macros shared by the exec core RTL.
`ifndef TWO_REGISTER_MEMORY_MACHINE_EXEC_CORE_MACROS_SVH
`define TWO_REGISTER_MEMORY_MACHINE_EXEC_CORE_MACROS_SVH

// Check that expr holds in the same cycle as cond.
`define TRMM_ASSERT_IMPLIES(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that expr holds in the cycle after cond.
`define TRMM_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

// Check that cond never holds.
`define TRMM_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### rtl/trmm_pkg.sv
// Types and constants of the two-register memory machine exec core.
package trmm_pkg;

	localparam int WORD_W    = 32;
	localparam int ADDR_W    = 10;
	localparam int FUNC_W    = 3;
	localparam int SEL_W     = 2;
	localparam int ADDR_SPAN = 1 << ADDR_W;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [SEL_W-1:0]  sel_t;

	localparam func_t FUNC_ADD    = 3'd0;
	localparam func_t FUNC_SUB    = 3'd1;
	localparam func_t FUNC_STORE  = 3'd2;
	localparam func_t FUNC_LOAD   = 3'd3;
	localparam func_t FUNC_LOADI  = 3'd4;
	localparam func_t FUNC_EXPORT = 3'd5;

	localparam sel_t SEL_FIRST  = 2'd1;
	localparam sel_t SEL_SECOND = 2'd2;

	// Result queue: one entry for the item in flight plus two waiting.
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 2;

	typedef struct packed {
		word_t value;
		logic  ok;
	} result_t;

endpackage

### rtl/two_register_memory_machine_exec_core.sv
// Top level of the two-register memory machine exec core.
// The input is registered into stage one; out_valid rises once its result is in the result queue.
// Throughput: one instruction per cycle while in_stall is low; reads go to two RAM copies, the write
// lands in the cycle after the reads and is forwarded to the next instruction.
// Reset: registers with a reset clear at once; a clearing pass then writes MEM_DEPTH zero words,
// one per cycle, with the input stalled until the pass ends.
`include "two_register_memory_machine_exec_core_macros.svh"

module two_register_memory_machine_exec_core #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [trmm_pkg::FUNC_W-1:0]          func,
	input  logic [trmm_pkg::ADDR_W-1:0]          first_address,
	input  logic [trmm_pkg::ADDR_W-1:0]          second_address,
	input  logic [trmm_pkg::ADDR_W-1:0]          result_address,
	input  logic [trmm_pkg::SEL_W-1:0]           reg_select,
	input  logic signed [trmm_pkg::WORD_W-1:0]   immediate,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [trmm_pkg::WORD_W-1:0]   export_value,
	output logic                                 export_valid
);

	import trmm_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam bit DEPTH_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
	localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

	// Reduce an address modulo the memory depth.
	function automatic logic [AW-1:0] mem_index(input addr_t addr);
		addr_t r;
		r = addr;
		if (!DEPTH_POW2 && MEM_DEPTH < ADDR_SPAN) begin
			for (int k = ADDR_W - 1; k >= 0; k--) begin
				if (32'(r) >= (MEM_DEPTH << k)) begin
					r = r - ADDR_W'(MEM_DEPTH << k);
				end
			end
		end
		return AW'(r);
	endfunction

	function automatic logic [FIFO_PTR_W-1:0] next_ptr(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic          valid_s1;
	func_t         func_s1;
	sel_t          sel_s1;
	word_t         imm_s1;
	logic [AW-1:0] a1_s1;
	logic [AW-1:0] a2_s1;
	logic [AW-1:0] a3_s1;

	word_t first_reg_q;
	word_t second_reg_q;
	word_t first_d;
	word_t second_d;

	logic          fwd_en_q;
	logic [AW-1:0] fwd_addr_q;
	word_t         fwd_data_q;

	logic [AW-1:0] rd_idx_a;
	logic [AW-1:0] rd_idx_b;
	word_t         rd_a;
	word_t         rd_b;
	word_t         x_op;
	word_t         y_op;
	word_t         arith;

	logic          wr_en;
	word_t         wr_data;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	word_t         ram_wdata;

	result_t                 res_d;
	result_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;
	logic [FIFO_CNT_W:0]     occupancy;
	logic                    accept;
	logic                    pop;

	// Input side: stall while clearing or while the result queue has no free slot.
	assign occupancy = {1'b0, cnt_q} + (FIFO_CNT_W + 1)'(valid_s1);
	assign in_stall  = clr_busy_q || (occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	assign accept    = in_valid && !in_stall;

	assign rd_idx_a = mem_index(first_address);
	assign rd_idx_b = mem_index(second_address);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		sel_s1  <= reg_select;
		imm_s1  <= $unsigned(immediate);
		a1_s1   <= rd_idx_a;
		a2_s1   <= rd_idx_b;
		a3_s1   <= mem_index(result_address);
	end

	trmm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_a),
		.rdata (rd_a)
	);

	trmm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_b),
		.rdata (rd_b)
	);

	// The write that landed on the edge of the read is not in the RAM output yet.
	assign x_op  = (fwd_en_q && fwd_addr_q == a1_s1) ? fwd_data_q : rd_a;
	assign y_op  = (fwd_en_q && fwd_addr_q == a2_s1) ? fwd_data_q : rd_b;
	assign arith = (func_s1 == FUNC_SUB) ? (x_op - y_op) : (x_op + y_op);

	always_comb begin
		first_d  = first_reg_q;
		second_d = second_reg_q;
		wr_en    = 1'b0;
		wr_data  = arith;
		res_d    = '0;
		if (valid_s1) begin
			unique case (func_s1) inside
				FUNC_ADD, FUNC_SUB: begin
					second_d = y_op;
					first_d  = arith;
					wr_en    = 1'b1;
				end
				FUNC_STORE: begin
					if (sel_s1 == SEL_FIRST) begin
						wr_en   = 1'b1;
						wr_data = first_reg_q;
					end else if (sel_s1 == SEL_SECOND) begin
						wr_en   = 1'b1;
						wr_data = second_reg_q;
					end
				end
				FUNC_LOAD: begin
					if (sel_s1 == SEL_FIRST) begin
						first_d = y_op;
					end else if (sel_s1 == SEL_SECOND) begin
						second_d = y_op;
					end
				end
				FUNC_LOADI: begin
					if (sel_s1 == SEL_FIRST) begin
						first_d = imm_s1;
					end else if (sel_s1 == SEL_SECOND) begin
						second_d = imm_s1;
					end
				end
				FUNC_EXPORT: begin
					if (sel_s1 == SEL_FIRST) begin
						res_d = '{value: first_reg_q, ok: 1'b1};
					end else if (sel_s1 == SEL_SECOND) begin
						res_d = '{value: second_reg_q, ok: 1'b1};
					end
				end
				default: ;
			endcase
		end
	end

	// Load and store share the second address; add and subtract write the result address.
	assign ram_we    = clr_busy_q || wr_en;
	assign ram_waddr = clr_busy_q ? clr_addr_q
	                 : ((func_s1 == FUNC_STORE) ? a2_s1 : a3_s1);
	assign ram_wdata = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_reg_q  <= '0;
			second_reg_q <= '0;
			fwd_en_q     <= 1'b0;
		end else begin
			first_reg_q  <= first_d;
			second_reg_q <= second_d;
			fwd_en_q     <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= ram_waddr;
		fwd_data_q <= ram_wdata;
	end

	// Result queue: push every finished instruction, pop on an output transaction.
	assign out_valid    = cnt_q != '0;
	assign pop          = out_valid && !out_stall;
	assign export_value = $signed(fifo_q[rd_ptr_q].value);
	assign export_valid = fifo_q[rd_ptr_q].ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(valid_s1) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= res_d;
		end
	end

	`TRMM_ASSERT_NEVER(a_fifo_no_overflow, valid_s1 && cnt_q == FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
	`TRMM_ASSERT_IMPLIES(a_clear_quiet, clr_busy_q, !valid_s1 && cnt_q == '0, "instruction in flight during clearing pass")
	`TRMM_ASSERT_NEXT(a_clear_full, clr_busy_q && clr_addr_q != LAST_IDX, clr_busy_q, "clearing pass ended early")

endmodule

### rtl/trmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
